[sv/srsw_pkg.sv]
`timescale 1ns / 1ps

package srsw_pkg;

    localparam int SEQ_COUNT    = 8;
    localparam int SEQ_BITS     = $clog2(SEQ_COUNT);
    localparam int PAYLOAD_BITS = 32;
    localparam int WSIZE_BITS   = 3;

    localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = WSIZE_BITS'(4);

    // event kinds
    localparam logic [1:0] FUNC_SEND   = 2'd0;
    localparam logic [1:0] FUNC_ACK    = 2'd1;
    localparam logic [1:0] FUNC_EXPIRE = 2'd2;

    // timer actions
    localparam logic [1:0] TIMER_NONE    = 2'd0;
    localparam logic [1:0] TIMER_RESTART = 2'd1;
    localparam logic [1:0] TIMER_STOP    = 2'd2;

    // ack status codes
    localparam logic [1:0] ACK_NONE     = 2'd0;
    localparam logic [1:0] ACK_ACCEPTED = 2'd1;
    localparam logic [1:0] ACK_CORRUPT  = 2'd2;
    localparam logic [1:0] ACK_REJECTED = 2'd3;

    typedef logic [SEQ_BITS-1:0] t_seq;

    typedef struct packed {
        logic [1:0]              func;
        logic [PAYLOAD_BITS-1:0] message_payload;
        t_seq                    ack_number;
        logic                    ack_checksum_ok;
        t_seq                    expired_sequence;
    } t_in_word;

    typedef struct packed {
        logic                    send_accepted;
        logic                    transmit_valid;
        t_seq                    packet_sequence;
        logic [PAYLOAD_BITS-1:0] packet_payload;
        logic [1:0]              timer_action;
        t_seq                    timer_sequence;
        logic [1:0]              ack_status;
        logic                    window_full;
    } t_out_word;

    // scanner status back to the sequencer
    typedef struct packed {
        logic busy;
        logic found;
        t_seq ptr;
    } t_scan_stat;

endpackage

[sv/srsw_scan.sv]
`timescale 1ns / 1ps

// Walks the outstanding mask one entry per cycle from a start point and
// stops at the first marked entry. Caller guarantees at least one mark.
module srsw_scan
    import srsw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_seq                 i_start_ptr,
    input  logic [SEQ_COUNT-1:0] i_mask,
    output t_scan_stat           o_stat
);

    logic r_busy;
    t_seq r_ptr;
    logic hit;

    assign hit = r_busy && i_mask[r_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (hit) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ptr <= i_start_ptr;
        end else if (r_busy && !hit) begin
            r_ptr <= r_ptr + t_seq'(1);
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.found = hit;
    assign o_stat.ptr   = r_ptr;

endmodule

[sv/selective_repeat_sender_window_unit.sv]
`timescale 1ns / 1ps

// Selective-repeat ARQ sender window. Each input word is one event: send a
// message, an acknowledgment arrives, or a retransmission timer expires. Each
// event produces exactly one output word describing what to put on the network,
// what to do with the per-sequence timer, the ack verdict and whether the
// window is full afterwards. Timers and checksums live outside the block.
// Flow: an accepted event is registered and decided in the EXEC state, and
// its result is handed to the output register from the FIN state. The window
// base does not move by scanning for sends, expiries, rejected acks, or an ack
// that empties the window. When an accepted ack leaves other entries
// outstanding, a SCAN state comes between EXEC and FIN: a single scanner checks
// one mask entry per cycle starting at the old base, until it finds the oldest
// outstanding entry. A stalled output holds the block in FIN. Input stall stays
// high until the event has been placed in the output register; a waiting result
// does not block the next event. window_size must be written over the config
// port only while the block is idle; the block itself does not enforce it.
// cfg ready is always high.
module selective_repeat_sender_window_unit
    import srsw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // event input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    // window_size register write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [WSIZE_BITS-1:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;   // waiting for an event
    localparam logic [1:0] S_EXEC = 2'd1;   // decide, update window state
    localparam logic [1:0] S_SCAN = 2'd2;   // base slides to oldest outstanding
    localparam logic [1:0] S_FIN  = 2'd3;   // hand result to output register

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    t_in_word                r_in;
    logic [PAYLOAD_BITS-1:0] r_rd_data;
    logic [PAYLOAD_BITS-1:0] r_mem [SEQ_COUNT];
    t_seq                    r_next;
    t_seq                    r_base;
    logic [SEQ_COUNT-1:0]    r_mask;
    logic [SEQ_COUNT-1:0]    n_mask;
    logic [WSIZE_BITS-1:0]   r_wsize;
    t_out_word               r_res;
    t_out_word               n_res;
    t_out_word               r_out;
    logic                    r_out_valid;

    logic                    in_take;
    logic                    out_free;
    t_seq                    used;
    t_seq                    ack_off;
    logic                    send_ok;
    logic                    ack_hit;
    logic [SEQ_COUNT-1:0]    ack_bit;
    logic [SEQ_COUNT-1:0]    mask_rest;
    logic                    scan_start;
    logic                    mem_we;
    t_scan_stat              scan;
    t_out_word               fin_word;

    assign in_take     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // window arithmetic; sequence space is a power of two so it wraps
    assign used      = r_next - r_base;
    assign ack_off   = r_in.ack_number - r_base;
    assign send_ok   = WSIZE_BITS'(used) < r_wsize;
    assign ack_bit   = {{(SEQ_COUNT-1){1'b0}}, 1'b1} << r_in.ack_number;
    assign mask_rest = r_mask & ~ack_bit;
    assign ack_hit   = r_mask[r_in.ack_number] && (WSIZE_BITS'(ack_off) < r_wsize);

    // decision for the event held in r_in
    always_comb begin
        n_res      = '0;
        n_mask     = r_mask;
        n_state    = S_FIN;
        scan_start = 1'b0;
        mem_we     = 1'b0;
        unique case (r_in.func)
            FUNC_SEND: begin
                if (send_ok) begin
                    mem_we                = 1'b1;
                    n_mask                = r_mask | (
                        {{(SEQ_COUNT-1){1'b0}}, 1'b1} << r_next);
                    n_res.send_accepted   = 1'b1;
                    n_res.transmit_valid  = 1'b1;
                    n_res.packet_sequence = r_next;
                    n_res.packet_payload  = r_in.message_payload;
                    n_res.timer_action    = TIMER_RESTART;
                    n_res.timer_sequence  = r_next;
                end
            end
            FUNC_ACK: begin
                if (!r_in.ack_checksum_ok) begin
                    n_res.ack_status = ACK_CORRUPT;
                end else if (!ack_hit) begin
                    n_res.ack_status = ACK_REJECTED;
                end else begin
                    n_mask               = mask_rest;
                    n_res.ack_status     = ACK_ACCEPTED;
                    n_res.timer_action   = TIMER_STOP;
                    n_res.timer_sequence = r_in.ack_number;
                    if (mask_rest != '0) begin
                        scan_start = 1'b1;
                        n_state    = S_SCAN;
                    end
                end
            end
            FUNC_EXPIRE: begin
                if (r_mask[r_in.expired_sequence]) begin
                    n_res.transmit_valid  = 1'b1;
                    n_res.packet_sequence = r_in.expired_sequence;
                    n_res.packet_payload  = r_rd_data;
                    n_res.timer_action    = TIMER_RESTART;
                    n_res.timer_sequence  = r_in.expired_sequence;
                end
            end
            default: begin
            end
        endcase
    end

    srsw_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (scan_start && (r_state == S_EXEC)),
        .i_start_ptr (r_base),
        .i_mask      (r_mask),
        .o_stat      (scan)
    );

    // payload store: read on accept for expiries, written on accepted sends
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_rd_data <= r_mem[i_in_word.expired_sequence];
        end
        if ((r_state == S_EXEC) && mem_we) begin
            r_mem[r_next] <= r_in.message_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_word;
        end
        if (r_state == S_EXEC) begin
            r_res <= n_res;
        end
    end

    // sequencer and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_next  <= '0;
            r_base  <= '0;
            r_mask  <= '0;
            r_wsize <= WSIZE_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_wsize <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_mask  <= n_mask;
                    r_state <= n_state;
                    if (mem_we) begin
                        r_next <= r_next + t_seq'(1);
                    end
                    // accepted ack that empties the window: base jumps to next
                    if ((r_in.func == FUNC_ACK) && (n_res.ack_status == ACK_ACCEPTED)
                        && !scan_start) begin
                        r_base <= r_next;
                    end
                end
                S_SCAN: begin
                    if (scan.found) begin
                        r_base  <= scan.ptr;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result word with the window-full flag taken after all updates
    always_comb begin
        fin_word             = r_res;
        fin_word.window_full = (WSIZE_BITS'(used) >= r_wsize);
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_out <= fin_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

[verif/selective_repeat_sender_window_unit_tb.sv]
`timescale 1ns / 1ps

module selective_repeat_sender_window_unit_tb;
    import srsw_pkg::*;

    // Longest receiver hold used to fill the block and back up the input.
    localparam int RX_HOLD_CYCLES = 300;
    // Cycles with no word moving on any channel before the run is called hung.
    // Worst correct gap is the long receiver hold plus a worst-case base scan.
    localparam int STALL_LIMIT    = 3000;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs. Every input has a known value at time 0.
    // ------------------------------------------------------------------
    logic                  i_clk     = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_word   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [WSIZE_BITS-1:0] cfg_data  = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_word             o_out_word;
    logic                  o_cfg_ready;

    always #4 i_clk = ~i_clk;

    selective_repeat_sender_window_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the sender window. Updated at the edge where an event
    // word is accepted, so it always matches what the block has been told.
    // ------------------------------------------------------------------
    t_seq                    nxt_seq   = '0;
    t_seq                    win_base  = '0;
    logic [SEQ_COUNT-1:0]    pend_mask = '0;
    logic [PAYLOAD_BITS-1:0] saved_data [SEQ_COUNT];
    logic [WSIZE_BITS-1:0]   win_size  = WSIZE_RESET;

    // Replies the block owes us, oldest first.
    t_out_word window_replies [$];

    int  fail_count  = 0;
    bit  idle_on     = 1'b1;   // random gaps on both sides
    bit  hold_rx_req = 1'b0;   // ask the receiver for one long hold

    // Sequence numbers currently in use (next minus base, mod SEQ_COUNT).
    function automatic t_seq used_slots();
        return t_seq'(nxt_seq - win_base);
    endfunction

    // Advance the shadow window by one event and return the reply it causes.
    function automatic t_out_word window_reply(input t_in_word w);
        t_out_word r;
        t_seq      off;
        int        n;
        r = '0;
        case (w.func)
            FUNC_SEND: begin
                if (used_slots() < win_size) begin
                    saved_data[nxt_seq]  = w.message_payload;
                    pend_mask[nxt_seq]   = 1'b1;
                    r.send_accepted      = 1'b1;
                    r.transmit_valid     = 1'b1;
                    r.packet_sequence    = nxt_seq;
                    r.packet_payload     = w.message_payload;
                    r.timer_action       = TIMER_RESTART;
                    r.timer_sequence     = nxt_seq;
                    nxt_seq              = nxt_seq + t_seq'(1);
                end
            end
            FUNC_ACK: begin
                off = t_seq'(w.ack_number - win_base);
                if (!w.ack_checksum_ok) begin
                    r.ack_status = ACK_CORRUPT;
                end else if (off >= win_size || !pend_mask[w.ack_number]) begin
                    r.ack_status = ACK_REJECTED;
                end else begin
                    pend_mask[w.ack_number] = 1'b0;
                    r.timer_action   = TIMER_STOP;
                    r.timer_sequence = w.ack_number;
                    r.ack_status     = ACK_ACCEPTED;
                    // slide base to oldest outstanding, or to next when empty
                    if (pend_mask == '0) begin
                        win_base = nxt_seq;
                    end else begin
                        for (n = 0; n < SEQ_COUNT && !pend_mask[win_base]; n++)
                            win_base = win_base + t_seq'(1);
                    end
                end
            end
            FUNC_EXPIRE: begin
                if (pend_mask[w.expired_sequence]) begin
                    r.transmit_valid  = 1'b1;
                    r.packet_sequence = w.expired_sequence;
                    r.packet_payload  = saved_data[w.expired_sequence];
                    r.timer_action    = TIMER_RESTART;
                    r.timer_sequence  = w.expired_sequence;
                end
            end
            default: ;  // unknown event: no change
        endcase
        r.window_full = (used_slots() >= win_size);
        return r;
    endfunction

    function automatic t_in_word event_word(input logic [1:0] func,
                                            input logic [PAYLOAD_BITS-1:0] data,
                                            input t_seq ack, input logic ok,
                                            input t_seq expired);
        t_in_word w;
        w.func             = func;
        w.message_payload  = data;
        w.ack_number       = ack;
        w.ack_checksum_ok  = ok;
        w.expired_sequence = expired;
        return w;
    endfunction

    // Mostly protocol-shaped traffic: sends, good acks and expiries of
    // outstanding entries. noise_pct of the words are fully random, which
    // covers corrupt acks, stray acks and expiries, and unknown events.
    function automatic t_in_word random_event(input int unsigned noise_pct);
        t_in_word    w;
        t_seq        pend [$];
        int          i;
        int unsigned roll;
        w = event_word(FUNC_SEND, $urandom(), t_seq'($urandom_range(0, SEQ_COUNT-1)),
                       1'b1, t_seq'($urandom_range(0, SEQ_COUNT-1)));
        for (i = 0; i < SEQ_COUNT; i++)
            if (pend_mask[i]) pend.push_back(t_seq'(i));
        roll = $urandom_range(0, 99);
        if (roll < noise_pct) begin
            w.func            = 2'($urandom_range(0, 3));
            w.ack_checksum_ok = 1'($urandom_range(0, 1));
        end else if (pend.size() != 0) begin
            roll = $urandom_range(0, 9);
            if (roll >= 4 && roll < 8) begin
                w.func       = FUNC_ACK;
                w.ack_number = pend[$urandom_range(0, pend.size()-1)];
            end else if (roll >= 8) begin
                w.func             = FUNC_EXPIRE;
                w.expired_sequence = pend[$urandom_range(0, pend.size()-1)];
            end
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Event sender. Valid is left high after a word is taken so that the
    // next call can present its word back to back; idle gaps lower it.
    // ------------------------------------------------------------------
    task automatic send_event(input t_in_word w);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        window_replies.push_back(window_reply(w));
        if (idle_on && $urandom_range(0, 99) < 16) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int count, input int unsigned noise_pct);
        repeat (count) send_event(random_event(noise_pct));
    endtask

    // Stop offering words and wait until every owed reply has come back.
    task automatic wait_for_replies();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (window_replies.size() != 0) @(posedge i_clk);
    endtask

    // window_size write; only ever done with the block idle.
    task automatic set_window(input logic [WSIZE_BITS-1:0] size);
        wait_for_replies();
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        win_size = size;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, or one long counted hold on request.
    // ------------------------------------------------------------------
    initial begin : rx_stall_gen
        int hold_cnt;
        forever begin
            @(posedge i_clk);
            if (hold_rx_req) begin
                hold_rx_req = 1'b0;
                out_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < RX_HOLD_CYCLES; hold_cnt++)
                    @(posedge i_clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= idle_on && ($urandom_range(0, 99) < 16);
            end
        end
    end

    // ------------------------------------------------------------------
    // Reply checker: every word taken on the output is matched against the
    // oldest owed reply, one field at a time.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (window_replies.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none, actual 0x%0h",
                         $time, o_out_word);
                fail_count++;
            end else begin
                want = window_replies.pop_front();
                check_field("send_accepted", 32'(want.send_accepted),
                            32'(o_out_word.send_accepted));
                check_field("transmit_valid", 32'(want.transmit_valid),
                            32'(o_out_word.transmit_valid));
                check_field("packet_sequence", 32'(want.packet_sequence),
                            32'(o_out_word.packet_sequence));
                check_field("packet_payload", 32'(want.packet_payload),
                            32'(o_out_word.packet_payload));
                check_field("timer_action", 32'(want.timer_action),
                            32'(o_out_word.timer_action));
                check_field("timer_sequence", 32'(want.timer_sequence),
                            32'(o_out_word.timer_sequence));
                check_field("ack_status", 32'(want.ack_status),
                            32'(o_out_word.ack_status));
                check_field("window_full", 32'(want.window_full),
                            32'(o_out_word.window_full));
            end
        end
    end

    // Hang detector: counts cycles in which no word moves on any channel.
    always @(posedge i_clk) begin : hang_watch
        int quiet_cycles;
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset window of 4: fill, refuse, every ack verdict, expiries hit and
    // miss, unknown event, base sliding past acked holes and emptying.
    task automatic test_directed_cases();
        send_event(event_word(FUNC_SEND, 32'h0000_0000, 3'd0, 1'b1, 3'd0));
        send_event(event_word(FUNC_SEND, 32'hFFFF_FFFF, 3'd7, 1'b0, 3'd7));
        send_event(event_word(FUNC_SEND, 32'hA5A5_A5A5, 3'd0, 1'b1, 3'd0));
        send_event(event_word(FUNC_SEND, 32'h5A5A_5A5A, 3'd0, 1'b1, 3'd0));
        // window full: refused
        send_event(event_word(FUNC_SEND, 32'h1234_5678, 3'd0, 1'b1, 3'd0));
        // corrupt ack of an outstanding entry
        send_event(event_word(FUNC_ACK, 32'hFFFF_FFFF, 3'd1, 1'b0, 3'd0));
        // good ack outside the window
        send_event(event_word(FUNC_ACK, 32'h0, 3'd5, 1'b1, 3'd0));
        // ack in the middle: base stays, then the same ack is a duplicate
        send_event(event_word(FUNC_ACK, 32'h0, 3'd2, 1'b1, 3'd0));
        send_event(event_word(FUNC_ACK, 32'h0, 3'd2, 1'b1, 3'd0));
        // expiry of an outstanding and of an acked entry
        send_event(event_word(FUNC_EXPIRE, 32'h0, 3'd0, 1'b0, 3'd3));
        send_event(event_word(FUNC_EXPIRE, 32'h0, 3'd0, 1'b0, 3'd2));
        // unknown event kind
        send_event(event_word(2'd3, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd7));
        // base ack, a send, then acks of 1 and 3: the base slides over the acked hole
        send_event(event_word(FUNC_ACK, 32'h0, 3'd0, 1'b1, 3'd0));
        send_event(event_word(FUNC_SEND, 32'h0F0F_0F0F, 3'd0, 1'b1, 3'd0));
        send_event(event_word(FUNC_ACK, 32'h0, 3'd1, 1'b1, 3'd0));
        send_event(event_word(FUNC_ACK, 32'h0, 3'd3, 1'b1, 3'd0));
        // last outstanding acked: base jumps to next
        send_event(event_word(FUNC_ACK, 32'h0, 3'd4, 1'b1, 3'd0));
        send_event(event_word(FUNC_EXPIRE, 32'h0, 3'd0, 1'b1, 3'd7));
        send_event(event_word(FUNC_SEND, 32'hDEAD_BEEF, 3'd0, 1'b1, 3'd0));
        send_event(event_word(FUNC_ACK, 32'h0, 3'd7, 1'b1, 3'd0));
        send_event(event_word(FUNC_EXPIRE, 32'h0, 3'd0, 1'b1, 3'd5));
        send_event(event_word(FUNC_ACK, 32'h0, 3'd5, 1'b1, 3'd0));
    endtask

    // Walk window_size through its range, extremes and out-of-range values.
    task automatic test_window_sweep();
        set_window(3'd1); send_random(60, 15);
        set_window(3'd2); send_random(60, 15);
        set_window(3'd3); send_random(60, 15);
        set_window(3'd0); send_random(40, 30);
        set_window(3'd7); send_random(60, 15);
        set_window(3'd4); send_random(60, 15);
    endtask

    // Long receiver hold while events keep coming: block fills, input stalls.
    task automatic test_backpressure_fill();
        hold_rx_req = 1'b1;
        send_random(40, 10);
    endtask

    // Sender pauses until the block has returned everything owed.
    task automatic test_drain_pause();
        send_random(20, 10);
        wait_for_replies();
        send_random(20, 10);
    endtask

    // Bulk random traffic: first a run with no gaps on either side.
    task automatic test_long_random();
        idle_on = 1'b0;
        send_random(150, 10);
        idle_on = 1'b1;
        set_window(3'd2);
        send_random(100, 10);
        set_window(3'd4);
        send_random(200, 10);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_window_sweep();
        test_backpressure_fill();
        test_drain_pause();
        test_long_random();

        wait_for_replies();
        // room for a late word after a worst-case base scan
        repeat (SEQ_COUNT + 8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
